>>> hw/rtl/kets_pkg.sv
// Package for the key expiry table sweeper.
// Field widths, register codes, reset values and the controller/datapath structs.
// No dependencies; every other file imports it.
package kets_pkg;

  localparam int TABLE_ENTRIES_DEF = 256;
  localparam int KEY_BITS_DEF      = 16;

  localparam int MODE_W    = 1;
  localparam int KEY_W     = 16;
  localparam int TIME_W    = 64;
  localparam int STATUS_W  = 1;
  localparam int EXPIRED_W = 11;
  localparam int LIVE_W    = 9;
  localparam int CYCLES_W  = 32;

  localparam int SAMPLE_W = 7;
  localparam int BATCH_W  = 5;

  localparam logic [SAMPLE_W-1:0] SAMPLE_RESET = SAMPLE_W'(20);
  localparam logic [BATCH_W-1:0]  BATCH_RESET  = BATCH_W'(10);
  // a batch that removes at most batch_len/4 entries ends the sweep
  localparam int LOW_HIT_SHIFT = 2;

  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;

  localparam logic REG_BATCH_LEN   = 1'b0;
  localparam logic REG_MAX_BATCHES = 1'b1;

  localparam logic MODE_SET   = 1'b0;
  localparam logic MODE_SWEEP = 1'b1;

  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FULL = 1'b1;

  typedef struct packed {
    logic clr;
    logic load;
    logic scan;
    logic commit;
    logic emit;
  } kets_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic req_sweep;
    logic sweep_skip;
    logic mode_sweep;
    logic scan_done;
    logic out_free;
  } kets_sts_t;

endpackage

>>> hw/rtl/kets_if.sv
// Request and result channel interfaces for the key expiry table sweeper.
// Depends on kets_pkg.
interface kets_req_if;
  import kets_pkg::*;
  logic                valid;
  logic                ready;
  logic [MODE_W-1:0]   mode;
  logic [KEY_W-1:0]    key_id;
  logic [TIME_W-1:0]   expiry_ms;
  logic [TIME_W-1:0]   now_ms;

  modport source (output valid, mode, key_id, expiry_ms, now_ms, input ready);
  modport sink   (input valid, mode, key_id, expiry_ms, now_ms, output ready);
endinterface

interface kets_rsp_if;
  import kets_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [STATUS_W-1:0]  status;
  logic [EXPIRED_W-1:0] removed_count;
  logic [LIVE_W-1:0]    live_keys;
  logic [CYCLES_W-1:0]  cycles_run;

  modport source (output valid, status, removed_count, live_keys, cycles_run, input ready);
  modport sink   (input valid, status, removed_count, live_keys, cycles_run, output ready);
endinterface

>>> hw/rtl/kets_cfg.sv
// APB register block: batch_len and max_batches.
// Depends on kets_pkg.
module kets_cfg (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [kets_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [kets_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [kets_pkg::APB_DATA_W-1:0]  prdata,
  output logic                             pready,
  output logic [kets_pkg::SAMPLE_W-1:0]    batch_len,
  output logic [kets_pkg::BATCH_W-1:0]     max_batches
);
  import kets_pkg::*;

  logic wr_en;
  logic reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_sel = paddr[2];

  always_ff @(posedge clk) begin
    if (rst) begin
      batch_len   <= SAMPLE_RESET;
      max_batches <= BATCH_RESET;
    end else if (wr_en) begin
      unique case (reg_sel)
        REG_BATCH_LEN:   batch_len   <= pwdata[SAMPLE_W-1:0];
        REG_MAX_BATCHES: max_batches <= pwdata[BATCH_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_BATCH_LEN:   prdata = APB_DATA_W'(batch_len);
      REG_MAX_BATCHES: prdata = APB_DATA_W'(max_batches);
      default:         prdata = '0;
    endcase
  end

endmodule

>>> hw/rtl/kets_ctrl.sv
// Controller: clearing pass, request intake, table scan, commit and result hand-off.
// Depends on kets_pkg.
module kets_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_ready,
  input  kets_pkg::kets_sts_t sts,
  output kets_pkg::kets_cmd_t cmd
);
  import kets_pkg::*;

  typedef enum logic [4:0] {
    S_CLEAR  = 5'b00001,
    S_IDLE   = 5'b00010,
    S_SCAN   = 5'b00100,
    S_COMMIT = 5'b01000,
    S_EMIT   = 5'b10000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  assign req_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_CLEAR: begin
        cmd.clr = 1'b1;
        if (sts.clr_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (req_valid) begin
          cmd.load = 1'b1;
          if (sts.req_sweep && sts.sweep_skip) begin
            state_next = S_EMIT;
          end else begin
            state_next = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_done) begin
          state_next = sts.mode_sweep ? S_EMIT : S_COMMIT;
        end
      end
      S_COMMIT: begin
        cmd.commit = 1'b1;
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase
  end

endmodule

>>> hw/rtl/kets_dp.sv
// Datapath: slot memories, scan pipeline, set search, sweep batching, counters, result register.
// Depends on kets_pkg.
module kets_dp #(
  parameter int TABLE_ENTRIES = kets_pkg::TABLE_ENTRIES_DEF,
  parameter int KEY_BITS      = kets_pkg::KEY_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  kets_pkg::kets_cmd_t             cmd,
  output kets_pkg::kets_sts_t             sts,
  input  logic [kets_pkg::SAMPLE_W-1:0]   batch_len,
  input  logic [kets_pkg::BATCH_W-1:0]    max_batches,
  input  logic [kets_pkg::MODE_W-1:0]     in_mode,
  input  logic [kets_pkg::KEY_W-1:0]      in_key_id,
  input  logic [kets_pkg::TIME_W-1:0]     in_expiry_ms,
  input  logic [kets_pkg::TIME_W-1:0]     in_now_ms,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [kets_pkg::STATUS_W-1:0]   out_status,
  output logic [kets_pkg::EXPIRED_W-1:0]  out_removed_count,
  output logic [kets_pkg::LIVE_W-1:0]     out_live_keys,
  output logic [kets_pkg::CYCLES_W-1:0]   out_cycles_run
);
  import kets_pkg::*;

  localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CW = $clog2(TABLE_ENTRIES + 1);
  localparam logic [IW-1:0] LAST_ADDR = IW'(TABLE_ENTRIES - 1);

  logic                valid_mem [TABLE_ENTRIES];
  logic [KEY_BITS-1:0] key_mem   [TABLE_ENTRIES];
  logic [TIME_W-1:0]   exp_mem   [TABLE_ENTRIES];

  // scan pipeline
  logic [IW-1:0]       rd_addr;
  logic                rd_issued;
  logic                pipe_vld;
  logic [IW-1:0]       pipe_addr;
  logic                pipe_last;
  logic                rd_valid_q;
  logic [KEY_BITS-1:0] rd_key_q;
  logic [TIME_W-1:0]   rd_exp_q;

  // captured request
  logic                mode_q;
  logic [KEY_BITS-1:0] key_q;
  logic [TIME_W-1:0]   exp_q;
  logic [TIME_W-1:0]   now_q;

  // set search
  logic                match_found;
  logic [IW-1:0]       match_addr;
  logic                free_found;
  logic [IW-1:0]       free_addr;

  // sweep batching
  logic [SAMPLE_W-1:0] checked;
  logic [SAMPLE_W-1:0] hits;
  logic [BATCH_W-1:0]  batch;
  logic [CW-1:0]       removed;

  logic [CW-1:0]       live_cnt;
  logic [CYCLES_W-1:0] sweep_cnt;
  logic                status_q;

  logic                issue;
  logic                last_addr;
  logic                ev;
  logic                ev_set;
  logic                ev_sweep;
  logic                set_hit;
  logic                exp_hit;
  logic [SAMPLE_W-1:0] checked_inc;
  logic [SAMPLE_W-1:0] hits_inc;
  logic                batch_full;
  logic [BATCH_W:0]    batch_inc;
  logic                stop_low;
  logic                stop_max;
  logic                sweep_stop;
  logic                set_stop;
  logic                insert;

  logic                vmem_we;
  logic                vmem_wd;
  logic                kmem_we;
  logic                emem_we;
  logic [IW-1:0]       wr_addr;

  assign issue     = cmd.scan && !rd_issued;
  assign last_addr = (rd_addr == LAST_ADDR);
  assign ev        = cmd.scan && pipe_vld;
  assign ev_set    = ev && (mode_q == MODE_SET);
  assign ev_sweep  = ev && (mode_q == MODE_SWEEP);

  assign set_hit     = rd_valid_q && (rd_key_q == key_q);
  assign exp_hit     = rd_valid_q && (rd_exp_q <= now_q);
  assign checked_inc = checked + SAMPLE_W'(rd_valid_q);
  assign hits_inc    = hits + SAMPLE_W'(exp_hit);
  assign batch_full  = rd_valid_q && (checked_inc == batch_len);
  assign batch_inc   = {1'b0, batch} + (BATCH_W+1)'(1);
  assign stop_low    = hits_inc <= (batch_len >> LOW_HIT_SHIFT);
  assign stop_max    = batch_inc >= {1'b0, max_batches};
  assign sweep_stop  = pipe_last || (batch_full && (stop_low || stop_max));
  assign set_stop    = set_hit || pipe_last;
  assign insert      = cmd.commit && !match_found && free_found;

  assign vmem_we = cmd.clr || (ev_sweep && exp_hit) || insert;
  assign vmem_wd = cmd.commit;
  assign kmem_we = insert;
  assign emem_we = cmd.commit && (match_found || free_found);

  always_comb begin
    if (cmd.clr) begin
      wr_addr = rd_addr;
    end else if (cmd.commit) begin
      wr_addr = match_found ? match_addr : free_addr;
    end else begin
      wr_addr = pipe_addr;
    end
  end

  always_comb begin
    sts            = '0;
    sts.clr_last   = last_addr;
    sts.req_sweep  = (in_mode == MODE_SWEEP);
    sts.sweep_skip = (live_cnt == '0) || (max_batches == '0) || (batch_len == '0);
    sts.mode_sweep = (mode_q == MODE_SWEEP);
    sts.scan_done  = ev && ((mode_q == MODE_SWEEP) ? sweep_stop : set_stop);
    sts.out_free   = !out_valid || out_ready;
  end

  // slot memories, registered read port on rd_addr
  always_ff @(posedge clk) begin
    if (vmem_we) begin
      valid_mem[wr_addr] <= vmem_wd;
    end
    if (kmem_we) begin
      key_mem[wr_addr] <= key_q;
    end
    if (emem_we) begin
      exp_mem[wr_addr] <= exp_q;
    end
    rd_valid_q <= valid_mem[rd_addr];
    rd_key_q   <= key_mem[rd_addr];
    rd_exp_q   <= exp_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_addr   <= '0;
      rd_issued <= 1'b0;
      pipe_vld  <= 1'b0;
    end else begin
      pipe_vld <= issue;
      if (cmd.load) begin
        rd_addr   <= '0;
        rd_issued <= 1'b0;
      end else if (cmd.clr || issue) begin
        if (last_addr) begin
          rd_addr   <= '0;
          rd_issued <= cmd.scan;
        end else begin
          rd_addr <= rd_addr + IW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    pipe_addr <= rd_addr;
    pipe_last <= last_addr;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_q      <= in_mode;
      key_q       <= KEY_BITS'(in_key_id);
      exp_q       <= in_expiry_ms;
      now_q       <= in_now_ms;
      match_found <= 1'b0;
      free_found  <= 1'b0;
      checked     <= '0;
      hits        <= '0;
      batch       <= '0;
      removed     <= '0;
      status_q    <= STATUS_OK;
    end else begin
      if (ev_set) begin
        if (set_hit) begin
          match_found <= 1'b1;
          match_addr  <= pipe_addr;
        end
        if (!rd_valid_q && !free_found) begin
          free_found <= 1'b1;
          free_addr  <= pipe_addr;
        end
      end
      if (ev_sweep) begin
        if (exp_hit) begin
          removed <= removed + CW'(1);
        end
        if (batch_full) begin
          checked <= '0;
          hits    <= '0;
          batch   <= batch_inc[BATCH_W-1:0];
        end else begin
          checked <= checked_inc;
          hits    <= hits_inc;
        end
      end
      if (cmd.commit && !match_found && !free_found) begin
        status_q <= STATUS_FULL;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      live_cnt  <= '0;
      sweep_cnt <= '0;
    end else begin
      if (cmd.load && (in_mode == MODE_SWEEP) && (sweep_cnt != '1)) begin
        sweep_cnt <= sweep_cnt + CYCLES_W'(1);
      end
      if (ev_sweep && exp_hit) begin
        live_cnt <= live_cnt - CW'(1);
      end else if (insert) begin
        live_cnt <= live_cnt + CW'(1);
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_status        <= status_q;
      out_removed_count <= EXPIRED_W'(removed);
      out_live_keys     <= LIVE_W'(live_cnt);
      out_cycles_run    <= sweep_cnt;
    end
  end

endmodule

>>> hw/rtl/key_expiry_table_sweeper_top.sv
// Top level of the key expiry table sweeper: controller, datapath and APB registers.
// Depends on kets_pkg, kets_if, kets_cfg, kets_ctrl and kets_dp.
//
//   channel   dir  handshake      payload
//   req       in   valid/ready    mode, key_id, expiry_ms, now_ms
//   rsp       out  valid/ready    status, removed_count, live_keys, cycles_run
//   apb       in   psel/penable   batch_len at 0x0, max_batches at 0x4
//
// One request at a time. A set walks the slot memory one entry a cycle, stopping at
// the slot that holds its key or at the last slot; a sweep skips the scan when nothing
// can be examined. After reset a clearing pass over every slot holds req.ready low.
// A stalled result is held in the output register; the next request is taken
// meanwhile and waits only to hand over its own result.
module key_expiry_table_sweeper_top #(
  parameter int TABLE_ENTRIES = kets_pkg::TABLE_ENTRIES_DEF,
  parameter int KEY_BITS      = kets_pkg::KEY_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  kets_req_if.sink                        req,
  kets_rsp_if.source                      rsp,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [kets_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [kets_pkg::APB_DATA_W-1:0] pwdata,
  output logic [kets_pkg::APB_DATA_W-1:0] prdata,
  output logic                            pready
);
  import kets_pkg::*;

  logic [SAMPLE_W-1:0] batch_len;
  logic [BATCH_W-1:0]  max_batches;
  kets_cmd_t           cmd;
  kets_sts_t           sts;

  kets_cfg u_cfg (
    .clk         (clk),
    .rst         (rst),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .batch_len   (batch_len),
    .max_batches (max_batches)
  );

  kets_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  kets_dp #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .KEY_BITS      (KEY_BITS)
  ) u_dp (
    .clk               (clk),
    .rst               (rst),
    .cmd               (cmd),
    .sts               (sts),
    .batch_len         (batch_len),
    .max_batches       (max_batches),
    .in_mode           (req.mode),
    .in_key_id         (req.key_id),
    .in_expiry_ms      (req.expiry_ms),
    .in_now_ms         (req.now_ms),
    .out_valid         (rsp.valid),
    .out_ready         (rsp.ready),
    .out_status        (rsp.status),
    .out_removed_count (rsp.removed_count),
    .out_live_keys     (rsp.live_keys),
    .out_cycles_run    (rsp.cycles_run)
  );

endmodule

>>> hw/rtl/kets_chk.sv
// Port-level checker for the key expiry table sweeper, bound to the top level.
// Depends on kets_pkg and key_expiry_table_sweeper_top.
module kets_chk #(
  parameter int TABLE_ENTRIES = kets_pkg::TABLE_ENTRIES_DEF
) (
  input logic                           clk,
  input logic                           rst,
  input logic                           req_valid,
  input logic                           req_ready,
  input logic                           rsp_valid,
  input logic                           rsp_ready,
  input logic [kets_pkg::STATUS_W-1:0]  rsp_status,
  input logic [kets_pkg::EXPIRED_W-1:0] rsp_removed_count,
  input logic [kets_pkg::LIVE_W-1:0]    rsp_live_keys,
  input logic [kets_pkg::CYCLES_W-1:0]  rsp_cycles_run
);
  import kets_pkg::*;

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
      && $stable(rsp_removed_count) && $stable(rsp_live_keys) && $stable(rsp_cycles_run))
    else $error("result changed while stalled");

  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("second request taken while one is in progress");

  a_full_no_removal: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (rsp_status == STATUS_OK) || (rsp_removed_count == '0))
    else $error("full flag together with removals");

  a_live_bound: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> 32'(rsp_live_keys) <= 32'(TABLE_ENTRIES))
    else $error("live count beyond table size");

endmodule

bind key_expiry_table_sweeper_top kets_chk #(
  .TABLE_ENTRIES (TABLE_ENTRIES)
) u_kets_chk (
  .clk               (clk),
  .rst               (rst),
  .req_valid         (req.valid),
  .req_ready         (req.ready),
  .rsp_valid         (rsp.valid),
  .rsp_ready         (rsp.ready),
  .rsp_status        (rsp.status),
  .rsp_removed_count (rsp.removed_count),
  .rsp_live_keys     (rsp.live_keys),
  .rsp_cycles_run    (rsp.cycles_run)
);

>>> sim/tb_top.sv
// Self-checking testbench for the key expiry table sweeper.
// Uses kets_pkg and the kets_req_if / kets_rsp_if channels; the DUT is checked
// against a shadow copy of the table, written and swept as each request is taken.
`timescale 1ns / 100ps

module tb_top;
  import kets_pkg::*;

  typedef struct packed {
    logic [STATUS_W-1:0]  status;
    logic [EXPIRED_W-1:0] expired;
    logic [LIVE_W-1:0]    live;
    logic [CYCLES_W-1:0]  cycles;
  } reply_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [APB_ADDR_W-1:0] paddr = '0;
  logic [APB_DATA_W-1:0] pwdata = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic pready;

  kets_req_if req_i ();
  kets_rsp_if rsp_i ();

  key_expiry_table_sweeper_top uut (
    .clk     (clk),
    .rst     (rst),
    .req     (req_i),
    .rsp     (rsp_i),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #5 clk = ~clk;

  // shadow table
  bit                  shadow_valid  [TABLE_ENTRIES_DEF];
  logic [KEY_W-1:0]    shadow_key    [TABLE_ENTRIES_DEF];
  logic [TIME_W-1:0]   shadow_expiry [TABLE_ENTRIES_DEF];
  logic [CYCLES_W-1:0] shadow_sweeps;
  logic [LIVE_W-1:0]   shadow_live;
  logic [SAMPLE_W-1:0] shadow_sample;
  logic [BATCH_W-1:0]  shadow_batches;

  reply_t expected_replies[$];
  int     errors = 0;
  int     items_sent = 0;
  bit     idle_on = 1'b1;
  int     stall_left = 0;
  logic [TIME_W-1:0] wall_ms = '0;
  logic [KEY_W-1:0]  key_base = '0;

  function automatic logic [STATUS_W-1:0] shadow_set(input logic [KEY_W-1:0] key,
                                                     input logic [TIME_W-1:0] when);
    int i;
    for (i = 0; i < TABLE_ENTRIES_DEF; i++) begin
      if (shadow_valid[i] && shadow_key[i] == key) begin
        shadow_expiry[i] = when;
        return STATUS_OK;
      end
    end
    for (i = 0; i < TABLE_ENTRIES_DEF; i++) begin
      if (!shadow_valid[i]) begin
        shadow_valid[i]  = 1'b1;
        shadow_key[i]    = key;
        shadow_expiry[i] = when;
        shadow_live++;
        return STATUS_OK;
      end
    end
    return STATUS_FULL;
  endfunction

  function automatic logic [EXPIRED_W-1:0] shadow_sweep(input logic [TIME_W-1:0] now);
    int removed, pos, batch, checked, hit;
    removed = 0;
    pos = 0;
    if (shadow_sweeps != '1) shadow_sweeps++;
    if (shadow_live == 0) return '0;
    for (batch = 0; batch < shadow_batches; batch++) begin
      checked = 0;
      hit = 0;
      while (checked < shadow_sample && pos < TABLE_ENTRIES_DEF) begin
        if (shadow_valid[pos]) begin
          if (shadow_expiry[pos] <= now) begin
            shadow_valid[pos] = 1'b0;
            shadow_live--;
            hit++;
          end
          checked++;
        end
        pos++;
      end
      removed += hit;
      if (checked < shadow_sample) break;
      if (hit <= (shadow_sample >> LOW_HIT_SHIFT)) break;
    end
    return EXPIRED_W'(removed);
  endfunction

  function automatic reply_t shadow_apply(input logic mode, input logic [KEY_W-1:0] key,
                                          input logic [TIME_W-1:0] exp_at,
                                          input logic [TIME_W-1:0] now);
    reply_t r;
    r = '0;
    if (mode == MODE_SWEEP) r.expired = shadow_sweep(now);
    else r.status = shadow_set(key, exp_at);
    r.live   = shadow_live;
    r.cycles = shadow_sweeps;
    return r;
  endfunction

  function automatic logic [TIME_W-1:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // result side: random back-pressure bursts
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      rsp_i.ready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 4) == 0) begin
      stall_left <= $urandom_range(0, 8);
      rsp_i.ready <= 1'b0;
    end else begin
      rsp_i.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    reply_t want;
    if (!rst && rsp_i.valid && rsp_i.ready) begin
      if (expected_replies.size() == 0) begin
        $display("%0t: unexpected reply status=%0d removed=%0d live=%0d cycles=%0d",
                 $time, rsp_i.status, rsp_i.removed_count, rsp_i.live_keys,
                 rsp_i.cycles_run);
        errors++;
      end else begin
        want = expected_replies.pop_front();
        if (rsp_i.status !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status, rsp_i.status);
          errors++;
        end
        if (rsp_i.removed_count !== want.expired) begin
          $display("%0t: removed_count expected %0d actual %0d", $time, want.expired,
                   rsp_i.removed_count);
          errors++;
        end
        if (rsp_i.live_keys !== want.live) begin
          $display("%0t: live_keys expected %0d actual %0d", $time, want.live,
                   rsp_i.live_keys);
          errors++;
        end
        if (rsp_i.cycles_run !== want.cycles) begin
          $display("%0t: cycles_run expected %0d actual %0d", $time, want.cycles,
                   rsp_i.cycles_run);
          errors++;
        end
      end
    end
  end

  task automatic send_request(input logic mode, input logic [KEY_W-1:0] key,
                              input logic [TIME_W-1:0] exp_at,
                              input logic [TIME_W-1:0] now);
    int gap;
    reply_t predicted;
    gap = 0;
    if (idle_on && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 9);
    if (gap != 0) begin
      req_i.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_i.valid        <= 1'b1;
    req_i.mode         <= mode;
    req_i.key_id       <= key;
    req_i.expiry_ms    <= exp_at;
    req_i.now_ms       <= now;
    do @(posedge clk); while (!req_i.ready);
    predicted = shadow_apply(mode, key, exp_at, now);
    expected_replies = {expected_replies, predicted};
    items_sent++;
  endtask

  task automatic wait_drained();
    req_i.valid <= 1'b0;
    @(posedge clk);
    while (expected_replies.size() != 0) @(posedge clk);
  endtask

  task automatic write_register(input logic idx, input logic [APB_DATA_W-1:0] value);
    logic [APB_DATA_W-1:0] want;
    logic [APB_DATA_W-1:0] got;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= APB_ADDR_W'(4 * idx);
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (idx == REG_BATCH_LEN) begin
      shadow_sample = value[SAMPLE_W-1:0];
      want = APB_DATA_W'(shadow_sample);
    end else begin
      shadow_batches = value[BATCH_W-1:0];
      want = APB_DATA_W'(shadow_batches);
    end
    // read back
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    got = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    if (got !== want) begin
      $display("%0t: register %0d readback expected %0d actual %0d", $time, idx, want, got);
      errors++;
    end
  endtask

  task automatic configure(input int sample, input int batches);
    wait_drained();
    write_register(REG_BATCH_LEN, {$urandom} << SAMPLE_W | APB_DATA_W'(sample));
    write_register(REG_MAX_BATCHES, {$urandom} << BATCH_W | APB_DATA_W'(batches));
  endtask

  task automatic clear_table();
    configure(127, 31);
    send_request(MODE_SWEEP, KEY_W'($urandom), rand64(), '1);
  endtask

  task automatic run_traffic(input int count, input int sweep_pct, input int span,
                             input int horizon);
    int i;
    logic [KEY_W-1:0]  key;
    logic [TIME_W-1:0] t;
    for (i = 0; i < count; i++) begin
      wall_ms += TIME_W'($urandom_range(0, 40));
      if ($urandom_range(0, 99) < sweep_pct) begin
        case ($urandom_range(0, 15))
          0:       t = '1;
          1:       t = '0;
          2:       t = rand64();
          default: t = wall_ms + TIME_W'($urandom_range(0, 200));
        endcase
        send_request(MODE_SWEEP, KEY_W'($urandom), rand64(), t);
      end else begin
        if ($urandom_range(0, 15) == 0) key = KEY_W'($urandom);
        else key = key_base + KEY_W'($urandom_range(0, span - 1));
        case ($urandom_range(0, 19))
          0:       t = '0;
          1:       t = '1;
          2:       t = rand64();
          default: t = wall_ms + TIME_W'($urandom_range(0, horizon));
        endcase
        send_request(MODE_SET, key, t, rand64());
      end
    end
  endtask

  task automatic test_directed_items();
    send_request(MODE_SWEEP, 16'h0000, '0, '0);
    send_request(MODE_SET, 16'h0000, '0, '1);
    send_request(MODE_SET, 16'hFFFF, '1, '0);
    send_request(MODE_SET, 16'h1234, 64'd100, '0);
    send_request(MODE_SET, 16'h1234, 64'd50, '0);
    send_request(MODE_SWEEP, 16'hFFFF, '1, 64'd49);
    send_request(MODE_SWEEP, 16'h0000, '0, 64'd50);
    send_request(MODE_SWEEP, 16'h0000, '0, '1);
    send_request(MODE_SWEEP, 16'h0000, '0, '1);
    send_request(MODE_SET, 16'hAAAA, {32{2'b01}}, {32{2'b10}});
    send_request(MODE_SET, 16'h5555, {32{2'b10}}, {32{2'b01}});
    send_request(MODE_SWEEP, 16'hAAAA, '0, {32{2'b01}});
    send_request(MODE_SWEEP, 16'h5555, '0, {32{2'b10}});
  endtask

  task automatic test_batch_limits();
    int i;
    // exact end of table after a full batch
    configure(4, 16);
    for (i = 0; i < 8; i++) send_request(MODE_SET, KEY_W'(i), '0, '0);
    send_request(MODE_SWEEP, '0, '0, '0);
    // stop on max_batches
    configure(2, 2);
    for (i = 0; i < 8; i++) send_request(MODE_SET, KEY_W'(i), '0, '0);
    send_request(MODE_SWEEP, '0, '0, '0);
    // zero batch length and zero batches remove nothing
    configure(0, 5);
    send_request(MODE_SWEEP, '0, '0, '1);
    configure(20, 0);
    send_request(MODE_SWEEP, '0, '0, '1);
    clear_table();
  endtask

  task automatic test_register_settings();
    int samples [7] = '{1, 64, 0, 127, 4, 2, 20};
    int batches [7] = '{1, 16, 5, 31, 0, 3, 10};
    int k;
    for (k = 0; k < 7; k++) begin
      configure(samples[k], batches[k]);
      key_base = KEY_W'($urandom);
      run_traffic($urandom_range(40, 80), 20, 96, 300);
    end
  endtask

  task automatic test_random_traffic();
    int seg;
    seg = 0;
    while (items_sent < 1700) begin
      key_base = KEY_W'($urandom);
      if (seg == 0) run_traffic(330, 0, 4096, 1000000);
      else begin
        case ($urandom_range(0, 3))
          0:       run_traffic(300, 3, 4096, 1000000);
          1, 2:    run_traffic($urandom_range(60, 200), 25, 64, 300);
          default: run_traffic($urandom_range(60, 150), 50, 65536, $urandom_range(1, 5000));
        endcase
      end
      if (seg == 0 || $urandom_range(0, 2) == 0) begin
        if ($urandom_range(0, 1) == 0) configure($urandom_range(1, 64), $urandom_range(1, 16));
        else configure($urandom_range(0, 127), $urandom_range(0, 31));
      end else if ($urandom_range(0, 2) == 0) begin
        wait_drained();
      end
      seg++;
    end
  endtask

  task automatic test_steady_stream();
    idle_on = 1'b0;
    key_base = KEY_W'($urandom);
    run_traffic(200, 25, 64, 300);
  endtask

  initial begin
    int i;
    for (i = 0; i < TABLE_ENTRIES_DEF; i++) begin
      shadow_valid[i]  = 1'b0;
      shadow_key[i]    = '0;
      shadow_expiry[i] = '0;
    end
    shadow_sweeps  = '0;
    shadow_live    = '0;
    shadow_sample  = SAMPLE_RESET;
    shadow_batches = BATCH_RESET;
    req_i.valid        = 1'b0;
    req_i.mode         = MODE_SET;
    req_i.key_id       = '0;
    req_i.expiry_ms    = '0;
    req_i.now_ms       = '0;
    rsp_i.ready        = 1'b0;
    wall_ms = rand64() >> 1;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed_items();
    test_batch_limits();
    test_register_settings();
    test_random_traffic();
    test_steady_stream();

    wait_drained();
    repeat (300) @(posedge clk);
    if (errors == 0 && expected_replies.size() == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    #30000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
